/* hdl/mas_pkg.sv */
// mas_pkg: shared constants and beat types for the multichannel adc smoothing core
// no dependencies; used by mas_stream_if and multichannel_adc_smoothing_core
package mas_pkg;

    // default geometry of the core
    localparam int CHANNELS_DEF      = 4;
    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int SMOOTH_SHIFT_DEF  = 4;

    // fixed field widths
    localparam int SAMPLE_W = 10;
    localparam int VALUE_W  = 11;
    localparam int CHAN_W   = 2;
    localparam int SWEEP_W  = 16;
    localparam int ACC_W    = 16;

    // one converter result
    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_sample;
    } sample_beat_t;

    // one smoothed result
    typedef struct packed {
        logic [CHAN_W-1:0]  sample_channel;
        logic [VALUE_W-1:0] smoothed_value;
        logic [CHAN_W-1:0]  next_channel;
        logic [SWEEP_W-1:0] sweep_number;
    } result_beat_t;

endpackage

/* hdl/mas_stream_if.sv */
// mas_stream_if: valid/ready channel carrying one beat of a given payload type
// depends on mas_pkg for the default payload type
interface mas_stream_if #(
    parameter type payload_t = mas_pkg::sample_beat_t
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/multichannel_adc_smoothing_core.sv */
// multichannel_adc_smoothing_core: per-channel leaky integrator and history mean
// depends on mas_pkg and mas_stream_if
//
//  channel   direction  payload                                          handshake
//  samples   sink       raw_sample                                       valid/ready
//  results   source     sample_channel, smoothed_value, next_channel,    valid/ready
//                       sweep_number
//
// one beat passes from acceptance through the update step, which updates the integrator and
// writes the history, the sum step, which sums the history through the single read port of
// the history memory, and the finish step, which loads the result register (the mean is a
// shift, or a reciprocal multiply in that same cycle when the depth is not a power of two);
// a new sample is accepted only in the idle state that follows the finish step.
// after reset the history memory is cleared, one entry a cycle, all CHANNELS * HISTORY_DEPTH
// entries, with samples.ready low. a waiting result does not block the next sample;
// only loading a new result waits for the result register to empty.
module multichannel_adc_smoothing_core #(
    parameter int CHANNELS      = mas_pkg::CHANNELS_DEF,
    parameter int HISTORY_DEPTH = mas_pkg::HISTORY_DEPTH_DEF,
    parameter int SMOOTH_SHIFT  = mas_pkg::SMOOTH_SHIFT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    mas_stream_if.sink   samples,
    mas_stream_if.source results
);

    // derived sizes
    localparam int DEPTH  = CHANNELS * HISTORY_DEPTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SL_W   = $clog2(HISTORY_DEPTH);
    localparam int RC_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = mas_pkg::VALUE_W + SL_W;
    localparam bit POW2   = (HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0;

    // reciprocal of the depth, exact for every sum below 2**SUM_W
    localparam int REC_W  = SUM_W + 1;
    localparam int REC_SH = SUM_W + SL_W;
    localparam int PROD_W = SUM_W + REC_W;
    localparam logic [REC_W-1:0] REC_M =
        REC_W'(((64'd1 << REC_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SUM,
        ST_FINISH
    } state_t;

    state_t                      state_reg;
    logic [AW-1:0]               clr_cnt_reg;
    logic [CH_W-1:0]             ch_reg;
    logic [SL_W-1:0]             slot_reg;
    logic [mas_pkg::SWEEP_W-1:0] sweep_reg;
    logic [mas_pkg::ACC_W-1:0]   integ_reg [CHANNELS];
    logic [mas_pkg::VALUE_W-1:0] sample_reg;
    logic [RC_W-1:0]             rd_cnt_reg;
    logic                        rd_pend_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic                        out_valid_reg;
    mas_pkg::result_beat_t       out_data_reg;

    // history memory
    logic [mas_pkg::VALUE_W-1:0] hist_mem [DEPTH];
    logic [mas_pkg::VALUE_W-1:0] mem_q_reg;

    logic                        mem_we;
    logic [AW-1:0]               mem_wa;
    logic [mas_pkg::VALUE_W-1:0] mem_wd;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [mas_pkg::ACC_W-1:0]   acc_cur;
    logic [mas_pkg::ACC_W-1:0]   acc_new;
    logic [PROD_W-1:0]           rec_prod;
    logic [SUM_W-1:0]            quot;
    logic [CH_W-1:0]             ch_next;
    logic [CH_W+1:0]             ch_ext;
    logic [CH_W+1:0]             ch_next_ext;
    logic                        out_free;

    // integrator update
    assign acc_cur = integ_reg[ch_reg];
    assign acc_new = acc_cur - (acc_cur >> SMOOTH_SHIFT)
                   + mas_pkg::ACC_W'(sample_reg);

    // memory port muxing
    assign mem_we  = (state_reg == ST_CLEAR) || (state_reg == ST_UPDATE);
    assign mem_wa  = (state_reg == ST_CLEAR) ? clr_cnt_reg
                   : AW'(32'(ch_reg) * HISTORY_DEPTH + 32'(slot_reg));
    assign mem_wd  = (state_reg == ST_CLEAR) ? '0
                   : mas_pkg::VALUE_W'(acc_new >> SMOOTH_SHIFT);
    assign rd_en   = (state_reg == ST_SUM) && (rd_cnt_reg < RC_W'(HISTORY_DEPTH));
    assign rd_addr = AW'(32'(ch_reg) * HISTORY_DEPTH + 32'(rd_cnt_reg[SL_W-1:0]));

    // history mean: shift for a power-of-two depth, else reciprocal multiply
    assign rec_prod = PROD_W'(sum_reg) * PROD_W'(REC_M);
    assign quot     = POW2 ? (sum_reg >> SL_W) : SUM_W'(rec_prod >> REC_SH);

    // channel sweep
    assign ch_next     = (ch_reg == CH_W'(CHANNELS - 1)) ? '0 : ch_reg + 1'b1;
    assign ch_ext      = {2'b00, ch_reg};
    assign ch_next_ext = {2'b00, ch_next};
    assign out_free    = !out_valid_reg || results.ready;

    assign samples.ready = (state_reg == ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // history memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            mem_q_reg <= hist_mem[rd_addr];
        end
    end

    // sequencer, datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            ch_reg        <= '0;
            slot_reg      <= '0;
            sweep_reg     <= '0;
            sample_reg    <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                integ_reg[i] <= '0;
            end
        end
        else
        begin
            // result taken; the finish step reloads the register itself
            if (results.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            rd_pend_reg <= rd_en;

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (samples.valid)
                    begin
                        sample_reg <= {samples.data.raw_sample, 1'b0};
                        state_reg  <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    integ_reg[ch_reg] <= acc_new;
                    rd_cnt_reg        <= '0;
                    sum_reg           <= '0;
                    state_reg         <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (rd_en)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    if (rd_pend_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(mem_q_reg);
                    end
                    else if (!rd_en)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.sample_channel  <= ch_ext[1:0];
                        out_data_reg.smoothed_value  <= quot[mas_pkg::VALUE_W-1:0];
                        out_data_reg.next_channel    <= ch_next_ext[1:0];
                        if (ch_reg == '0)
                        begin
                            out_data_reg.sweep_number <= sweep_reg + 1'b1;
                            sweep_reg                 <= sweep_reg + 1'b1;
                            slot_reg <= (slot_reg == SL_W'(HISTORY_DEPTH - 1))
                                        ? '0 : slot_reg + 1'b1;
                        end
                        else
                        begin
                            out_data_reg.sweep_number <= sweep_reg;
                        end
                        ch_reg    <= ch_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a new result only appears from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish step");

    // no sample taken while the history is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !samples.ready)
        else $error("sample ready during history clear");

    // an accepted sample always starts the integrator update
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> (state_reg == ST_UPDATE))
        else $error("accepted sample did not start update");
`endif

endmodule
